### rtl/spp_pkg.sv
// spp_pkg: shared types and constants for the screen point picker
// used by spp_ctrl, spp_datapath and screen_point_pick_nearest_unit
`timescale 1ns / 1ps
`default_nettype none

package spp_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_ROW0   = 3'd0;
	localparam logic [2:0] CFG_ROW1   = 3'd1;
	localparam logic [2:0] CFG_ROW2   = 3'd2;
	localparam logic [2:0] CFG_ROW3   = 3'd3;
	localparam logic [2:0] CFG_NROW   = 3'd4;
	localparam logic [2:0] CFG_MOUSE  = 3'd5;
	localparam logic [2:0] CFG_RADIUS = 3'd6;
	localparam logic [2:0] CFG_CULL   = 3'd7;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int IN_DATA_W  = 120;
	localparam int OUT_DATA_W = 56;
	localparam int IDX_W      = 20;

	localparam logic [23:0] RADIUS_RESET = 24'd1678;
	localparam logic [31:0] DEPTH_MAX    = 32'h7fff_ffff;
	localparam logic [31:0] DEPTH_MIN    = 32'h8000_0000;

	// multiplier row selector: rows 0..3 of the matrix, then the normal row
	localparam logic [2:0] ROW_NORMAL = 3'd4;
	localparam logic [1:0] COL_LAST   = 2'd2;

	// division targets
	localparam logic [1:0] DIV_X = 2'd0;
	localparam logic [1:0] DIV_Y = 2'd1;
	localparam logic [1:0] DIV_Z = 2'd2;

	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_MUL      = 9'b000000010,
		ST_MACC     = 9'b000000100,
		ST_DIV_GO   = 9'b000001000,
		ST_DIV_WAIT = 9'b000010000,
		ST_DIST1    = 9'b000100000,
		ST_DIST2    = 9'b001000000,
		ST_DECIDE   = 9'b010000000,
		ST_EMIT     = 9'b100000000
	} state_t;

	typedef struct packed {
		logic       load;
		logic       mul_en;
		logic [2:0] row;
		logic [1:0] col;
		logic       div_start;
		logic [1:0] div_sel;
		logic       dist1;
		logic       dist2;
		logic       update;
		logic       emit;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic last;
	} sts_t;

endpackage

`default_nettype wire

### rtl/spp_div.sv
// spp_div: restoring divider, one quotient bit per cycle, saturation flag
// depends on nothing but its ports
`timescale 1ns / 1ps
`default_nettype none

module spp_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        depth_mode,
	input  wire logic [41:0] num,
	input  wire logic [41:0] den,
	output logic             done,
	output logic             sat,
	output logic [32:0]      quot
);

	localparam int QB = 33;

	logic [65:0] ext;
	logic [41:0] rem_q;
	logic [32:0] low_q;
	logic [32:0] quot_q;
	logic        sat_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [42:0] shifted;
	logic [43:0] trial;

	// scaled numerator: depth takes 24 fraction bits, screen takes 14
	assign ext = depth_mode ? {num, 24'b0} : {10'b0, num, 14'b0};

	assign shifted = {rem_q, low_q[QB-1]};
	assign trial   = {1'b0, shifted} - {2'b0, den};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(QB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath of the divider
	always_ff @(posedge clk) begin
		if (start) begin
			sat_q  <= {9'b0, ext[65:33]} >= den;
			rem_q  <= {9'b0, ext[65:33]};
			low_q  <= ext[32:0];
			quot_q <= '0;
		end else if (busy_q) begin
			low_q <= {low_q[QB-2:0], 1'b0};
			if (!trial[43]) begin
				rem_q  <= trial[41:0];
				quot_q <= {quot_q[QB-2:0], 1'b1};
			end else begin
				rem_q  <= shifted[41:0];
				quot_q <= {quot_q[QB-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign sat  = sat_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

### rtl/spp_datapath.sv
// spp_datapath: config registers, shared multiplier, accumulators, pick state
// depends on spp_pkg and spp_div
`timescale 1ns / 1ps
`default_nettype none

module spp_datapath
	import spp_pkg::*;
#(
	parameter int MAX_POINTS = 1048576
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic                  s_tlast,
	input  wire cmd_t                  cmd,
	output sts_t                       sts,
	output logic [OUT_DATA_W-1:0]      m_tdata,
	output logic [0:0]                 m_tuser
);

	localparam int CW = $clog2(MAX_POINTS);

	// configuration
	logic [63:0] row_q [4];
	logic [47:0] nrow_q;
	logic [31:0] mouse_q;
	logic [23:0] rad_q;
	logic        cull_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) row_q[i] <= '0;
			nrow_q  <= '0;
			mouse_q <= '0;
			rad_q   <= RADIUS_RESET;
			cull_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROW0:   row_q[0] <= cfg_data;
				CFG_ROW1:   row_q[1] <= cfg_data;
				CFG_ROW2:   row_q[2] <= cfg_data;
				CFG_ROW3:   row_q[3] <= cfg_data;
				CFG_NROW:   nrow_q   <= cfg_data[47:0];
				CFG_MOUSE:  mouse_q  <= cfg_data[31:0];
				CFG_RADIUS: rad_q    <= cfg_data[23:0];
				CFG_CULL:   cull_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// captured point
	logic signed [23:0] crd_q [3];
	logic signed [15:0] nrm_q [3];
	logic               last_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      cnt_q;

	// shared multiplier operands
	logic signed [15:0] mul_a;
	logic signed [23:0] mul_b;
	logic signed [39:0] prod_s1;
	logic [2:0]         row_s1;
	logic               pv_s1;

	always_comb begin
		if (cmd.row == ROW_NORMAL) begin
			mul_a = nrow_q[16*cmd.col +: 16];
			mul_b = {{8{nrm_q[cmd.col][15]}}, nrm_q[cmd.col]};
		end else begin
			mul_a = row_q[cmd.row[1:0]][16*cmd.col +: 16];
			mul_b = crd_q[cmd.col];
		end
	end

	// accumulators
	logic signed [41:0] acc_q [4];
	logic signed [33:0] nacc_q;

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		row_s1  <= cmd.row;
		if (cmd.load) begin
			for (int i = 0; i < 3; i++) begin
				crd_q[i] <= s_tdata[24*i +: 24];
				nrm_q[i] <= s_tdata[72 + 16*i +: 16];
			end
			last_q <= s_tlast;
			idx_q  <= cnt_q;
			for (int r = 0; r < 4; r++)
				acc_q[r] <= {{14{row_q[r][63]}}, row_q[r][63:48], 12'b0};
			nacc_q <= '0;
		end else if (pv_s1) begin
			if (row_s1 == ROW_NORMAL)
				nacc_q <= nacc_q + {{2{prod_s1[31]}}, prod_s1[31:0]};
			else
				acc_q[row_s1[1:0]] <= acc_q[row_s1[1:0]] + {{2{prod_s1[39]}}, prod_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pv_s1 <= 1'b0;
		else         pv_s1 <= cmd.mul_en;
	end

	// divider feed
	logic signed [41:0] dnum;
	logic [41:0]        num_mag;
	logic [41:0]        den_mag;
	logic               div_done;
	logic               div_sat;
	logic [32:0]        div_quot;
	logic [1:0]         sel_q;
	logic               neg_q;

	always_comb begin
		case (cmd.div_sel)
			DIV_X:   dnum = acc_q[0];
			DIV_Y:   dnum = acc_q[1];
			default: dnum = acc_q[2];
		endcase
	end

	assign num_mag = dnum[41] ? 42'(-dnum) : dnum;
	assign den_mag = acc_q[3][41] ? 42'(-acc_q[3]) : acc_q[3];

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			sel_q <= cmd.div_sel;
			neg_q <= dnum[41] ^ acc_q[3][41];
		end
	end

	spp_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (cmd.div_start),
		.depth_mode (cmd.div_sel == DIV_Z),
		.num        (num_mag),
		.den        (den_mag),
		.done       (div_done),
		.sat        (div_sat),
		.quot       (div_quot)
	);

	// clamp quotients into screen and depth ranges
	logic signed [16:0] sx_q;
	logic signed [16:0] sy_q;
	logic signed [31:0] dep_q;
	logic signed [16:0] scr_val;
	logic [32:0]        dmag;
	logic [31:0]        dep_val;

	always_comb begin
		if (neg_q)
			scr_val = (div_sat || div_quot > 33'd65536) ? 17'h10000 : 17'(-div_quot);
		else
			scr_val = (div_sat || div_quot > 33'd65535) ? 17'h0ffff : div_quot[16:0];
		dmag = div_sat ? 33'h1_0000_0000 : div_quot;
		if (neg_q)
			dep_val = (dmag > 33'h0_8000_0000) ? DEPTH_MIN : 32'(-dmag);
		else
			dep_val = (dmag > 33'h0_7fff_ffff) ? DEPTH_MAX : dmag[31:0];
	end

	always_ff @(posedge clk) begin
		if (div_done) begin
			case (sel_q)
				DIV_X:   sx_q  <= scr_val;
				DIV_Y:   sy_q  <= scr_val;
				default: dep_q <= dep_val;
			endcase
		end
	end

	// squared distance, one multiply per cycle
	logic signed [17:0] dx;
	logic signed [17:0] dy;
	logic signed [35:0] sq_q;
	logic [36:0]        dist_q;
	logic signed [35:0] dy_sq;

	assign dx    = {sx_q[16], sx_q} - {{2{mouse_q[15]}}, mouse_q[15:0]};
	assign dy    = {sy_q[16], sy_q} - {{2{mouse_q[31]}}, mouse_q[31:16]};
	assign dy_sq = dy * dy;

	always_ff @(posedge clk) begin
		if (cmd.dist1) sq_q   <= dx * dx;
		if (cmd.dist2) dist_q <= {1'b0, sq_q} + {1'b0, dy_sq};
	end

	// candidate test and pick state
	logic               cand;
	logic signed [31:0] best_dep_q;
	logic [CW-1:0]      best_idx_q;
	logic               have_q;
	logic [CW+IDX_W-1:0] idx_ext;
	logic [IDX_W-1:0]   out_idx_q;
	logic [31:0]        out_dep_q;
	logic               out_found_q;

	assign cand = (acc_q[3] != '0) && (dist_q < {9'b0, rad_q, 4'b0})
		&& (!cull_q || nacc_q > 34'sd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_dep_q <= DEPTH_MAX;
			best_idx_q <= '0;
			have_q     <= 1'b0;
			cnt_q      <= '0;
		end else begin
			if (cmd.load)
				cnt_q <= (cnt_q == CW'(MAX_POINTS - 1)) ? '0 : cnt_q + 1'b1;
			if (cmd.update && cand && (!have_q || dep_q < best_dep_q)) begin
				best_dep_q <= dep_q;
				best_idx_q <= idx_q;
				have_q     <= 1'b1;
			end
			if (cmd.emit) begin
				best_dep_q <= DEPTH_MAX;
				best_idx_q <= '0;
				have_q     <= 1'b0;
				cnt_q      <= '0;
			end
		end
	end

	assign idx_ext = {{IDX_W{1'b0}}, best_idx_q};

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_found_q <= have_q;
			out_idx_q   <= have_q ? idx_ext[IDX_W-1:0] : '0;
			out_dep_q   <= have_q ? best_dep_q : '0;
		end
	end

	assign m_tdata      = {4'b0, out_dep_q, out_idx_q};
	assign m_tuser      = out_found_q;
	assign sts.div_done = div_done;
	assign sts.last     = last_q;

endmodule

`default_nettype wire

### rtl/spp_ctrl.sv
// spp_ctrl: sequencer for multiply, divide, distance and pick steps
// depends on spp_pkg
`timescale 1ns / 1ps
`default_nettype none

module spp_ctrl
	import spp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  wire logic m_tready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t     state_q;
	logic [2:0] row_q;
	logic [1:0] col_q;
	logic [1:0] sel_q;
	logic       ov_q;
	logic       mul_last;
	logic       emit_ok;

	assign s_tready = (state_q == ST_IDLE);
	assign mul_last = (row_q == ROW_NORMAL) && (col_q == COL_LAST);
	assign emit_ok  = (state_q == ST_EMIT) && (!ov_q || m_tready);

	// next state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			sel_q   <= DIV_X;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_MUL;
						row_q   <= '0;
						col_q   <= '0;
					end
				end
				ST_MUL: begin
					if (mul_last) begin
						state_q <= ST_MACC;
					end else if (col_q == COL_LAST) begin
						col_q <= '0;
						row_q <= row_q + 3'd1;
					end else begin
						col_q <= col_q + 2'd1;
					end
				end
				ST_MACC: begin
					state_q <= ST_DIV_GO;
					sel_q   <= DIV_X;
				end
				ST_DIV_GO: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (sts.div_done) begin
						if (sel_q == DIV_Z) begin
							state_q <= ST_DIST1;
						end else begin
							sel_q   <= sel_q + 2'd1;
							state_q <= ST_DIV_GO;
						end
					end
				end
				ST_DIST1:  state_q <= ST_DIST2;
				ST_DIST2:  state_q <= ST_DECIDE;
				ST_DECIDE: state_q <= sts.last ? ST_EMIT : ST_IDLE;
				ST_EMIT: begin
					if (emit_ok) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)      ov_q <= 1'b0;
		else if (emit_ok) ov_q <= 1'b1;
		else if (m_tready) ov_q <= 1'b0;
	end

	assign m_tvalid = ov_q;

	// commands
	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == ST_IDLE) && s_tvalid;
		cmd.mul_en    = (state_q == ST_MUL);
		cmd.row       = row_q;
		cmd.col       = col_q;
		cmd.div_start = (state_q == ST_DIV_GO);
		cmd.div_sel   = sel_q;
		cmd.dist1     = (state_q == ST_DIST1);
		cmd.dist2     = (state_q == ST_DIST2);
		cmd.update    = (state_q == ST_DECIDE);
		cmd.emit      = emit_ok;
	end

	// checks
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_MUL))
		else $error("accepted request did not start the multiply pass");

	a_mul_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && !mul_last) |=> (state_q == ST_MUL))
		else $error("multiply pass ended early");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == ST_DIV_WAIT))
		else $error("divider finished outside the wait state");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && ov_q && !m_tready) |=> (state_q == ST_EMIT && ov_q))
		else $error("pending result overwritten");

endmodule

`default_nettype wire

### rtl/screen_point_pick_nearest_unit.sv
// screen_point_pick_nearest_unit: top level of the screen-space point picker
// depends on spp_pkg, spp_ctrl, spp_datapath (and spp_div below it)
//
// channel  | dir | signals                          | content
// s_*      | in  | s_tvalid s_tready s_tdata s_tlast | one model point, tlast ends the set
// m_*      | out | m_tvalid m_tready m_tdata m_tuser | one pick result per set
// cfg_*    | in  | cfg_we cfg_index cfg_data         | register writes, no wait
//
// a point goes through these steps from one accept to the next: the accept,
// 15 steps on the shared 16x24 multiplier plus a drain step, three divider
// runs (start, 33 steps, done), then distance and compare
// a last point adds the emit state, which loads the result register
// arst_n resets the controller, config registers and pick state at once
// a result held by m_tready low stalls the block only when the next set ends
`timescale 1ns / 1ps
`default_nettype none

module screen_point_pick_nearest_unit
	import spp_pkg::*;
#(
	parameter int MAX_POINTS = 1048576
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// coord_x[23:0] coord_y[47:24] coord_z[71:48] normal_x[87:72]
	// normal_y[103:88] normal_z[119:104]
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic                  s_tlast,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// picked_index[19:0] picked_depth[51:20], zero fill above
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// found[0]
	output logic [0:0]                 m_tuser,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	spp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	spp_datapath #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cmd       (cmd),
		.sts       (sts),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

`default_nettype wire
